FILE: sv/dpd_pkg.sv
// shared types, register map and reset values for the deadband position drive
// no dependencies
package dpd_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_DEADBAND   = 3'd0;
    localparam logic [2:0] REG_STILL_TOL  = 3'd1;
    localparam logic [2:0] REG_STALL_LIM  = 3'd2;
    localparam logic [2:0] REG_ZERO_LEVEL = 3'd3;
    localparam logic [2:0] REG_FAR_LEVEL  = 3'd4;

    localparam logic [19:0] DEADBAND_RST   = 20'd2000;
    localparam logic [16:0] STILL_TOL_RST  = 17'd10;
    localparam logic [7:0]  STALL_LIM_RST  = 8'd50;
    localparam logic [16:0] ZERO_LEVEL_RST = 17'd1;
    localparam logic [30:0] FAR_LEVEL_RST  = 31'd7000000;

    localparam logic [7:0] STILL_CNT_MAX = 8'hFF;

    localparam logic signed [1:0] DRIVE_FWD  = 2'sb01;
    localparam logic signed [1:0] DRIVE_STOP = 2'sb00;
    localparam logic signed [1:0] DRIVE_REV  = 2'sb11;

    typedef struct packed {
        logic [19:0] deadband;
        logic [16:0] still_tolerance;
        logic [7:0]  stall_limit;
        logic [16:0] zero_target_level;
        logic [30:0] far_position_level;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] target_position;
        logic signed [31:0] measured_position;
    } in_item_t;

    typedef struct packed {
        logic signed [1:0] drive_direction;
        logic              reset_encoder;
        logic              power_cycle;
        logic              move_done;
        logic              finished;
    } out_item_t;

endpackage

FILE: sv/dpd_cfg_regs.sv
// apb configuration registers for the deadband position drive
// depends on dpd_pkg
module dpd_cfg_regs import dpd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deadband           <= DEADBAND_RST;
            cfg_reg.still_tolerance    <= STILL_TOL_RST;
            cfg_reg.stall_limit        <= STALL_LIM_RST;
            cfg_reg.zero_target_level  <= ZERO_LEVEL_RST;
            cfg_reg.far_position_level <= FAR_LEVEL_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DEADBAND:   cfg_reg.deadband           <= pwdata[19:0];
                REG_STILL_TOL:  cfg_reg.still_tolerance    <= pwdata[16:0];
                REG_STALL_LIM:  cfg_reg.stall_limit        <= pwdata[7:0];
                REG_ZERO_LEVEL: cfg_reg.zero_target_level  <= pwdata[16:0];
                REG_FAR_LEVEL:  cfg_reg.far_position_level <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DEADBAND:   prdata = {12'd0, cfg_reg.deadband};
            REG_STILL_TOL:  prdata = {15'd0, cfg_reg.still_tolerance};
            REG_STALL_LIM:  prdata = {24'd0, cfg_reg.stall_limit};
            REG_ZERO_LEVEL: prdata = {15'd0, cfg_reg.zero_target_level};
            REG_FAR_LEVEL:  prdata = {1'b0, cfg_reg.far_position_level};
            default:        prdata = '0;
        endcase
    end

endmodule

FILE: sv/dpd_core.sv
// control step: deadband, stall and homing decisions with position/count state
// depends on dpd_pkg
module dpd_core import dpd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step_en,
    input  cfg_t      cfg,
    input  in_item_t  item,
    output out_item_t result
);

    logic signed [31:0] prev_pos_reg, prev_pos_next;
    logic [7:0]         still_cnt_reg, still_cnt_next;

    logic signed [32:0] tgt_ext, meas_ext, prev_ext;
    logic signed [32:0] err, delta;
    logic [32:0]        err_abs, delta_abs;
    logic [7:0]         cnt_upd;
    logic               home, far_out, motionless, in_band, stall;

    always_comb begin
        tgt_ext   = {item.target_position[31], item.target_position};
        meas_ext  = {item.measured_position[31], item.measured_position};
        prev_ext  = {prev_pos_reg[31], prev_pos_reg};
        err       = tgt_ext - meas_ext;
        delta     = prev_ext - meas_ext;
        err_abs   = err[32] ? 33'(-err) : 33'(err);
        delta_abs = delta[32] ? 33'(-delta) : 33'(delta);

        home       = tgt_ext <= $signed({16'd0, cfg.zero_target_level});
        far_out    = meas_ext >= $signed({2'd0, cfg.far_position_level});
        motionless = delta_abs <= {16'd0, cfg.still_tolerance};
        in_band    = err_abs <= {13'd0, cfg.deadband};

        if (!motionless) begin
            cnt_upd = '0;
        end else if (still_cnt_reg == STILL_CNT_MAX) begin
            cnt_upd = still_cnt_reg;
        end else begin
            cnt_upd = still_cnt_reg + 8'd1;
        end
        stall = cnt_upd >= cfg.stall_limit;

        result         = '0;
        prev_pos_next  = prev_pos_reg;
        still_cnt_next = '0;
        if (home && far_out) begin
            result.reset_encoder   = 1'b1;
            result.power_cycle     = 1'b1;
            result.finished        = 1'b1;
            result.drive_direction = DRIVE_STOP;
        end else begin
            prev_pos_next = item.measured_position;
            if (in_band || stall) begin
                result.drive_direction = DRIVE_STOP;
                result.power_cycle     = stall || home;
                result.reset_encoder   = home;
                result.move_done       = 1'b1;
                result.finished        = 1'b1;
            end else begin
                still_cnt_next         = cnt_upd;
                result.drive_direction = err[32] ? DRIVE_REV : DRIVE_FWD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pos_reg  <= '0;
            still_cnt_reg <= '0;
        end else if (step_en) begin
            prev_pos_reg  <= prev_pos_next;
            still_cnt_reg <= still_cnt_next;
        end
    end

endmodule

FILE: sv/deadband_position_drive_with_stall.sv
// deadband position drive with stall detection, top level
// pipeline: input register feeding the control step, then the result register;
// throughput 1 beat per cycle unless m_ready low stalls the result register
// reset: synchronous active low, clears position/count state and loads register defaults
// depends on dpd_pkg, dpd_cfg_regs, dpd_core
module deadband_position_drive_with_stall import dpd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data
);

    cfg_t      cfg;
    in_item_t  in_data_reg;
    logic      in_valid_reg;
    out_item_t out_data_reg;
    logic      out_valid_reg;
    out_item_t step_result;
    logic      advance;
    logic      step_en;

    dpd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dpd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .cfg     (cfg),
        .item    (in_data_reg),
        .result  (step_result)
    );

    assign advance = !out_valid_reg || m_ready;
    assign step_en = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (step_en) begin
            out_data_reg <= step_result;
        end
    end

`ifndef ASSERT_OFF
    a_stop_iff_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.finished == (m_data.drive_direction == DRIVE_STOP)))
        else $error("drive must stop exactly when the move is finished");

    a_flags_need_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.move_done || m_data.reset_encoder || m_data.power_cycle)
        |-> m_data.finished)
        else $error("request flag raised on a tick that did not finish the move");

    a_reset_implies_power: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.reset_encoder |-> m_data.power_cycle)
        else $error("encoder reset without power cycle");

    a_result_follows_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg && !m_valid |=> !m_valid)
        else $error("result beat without an accepted input beat");
`endif

endmodule
